### rtl/core/stick_adc_reference_filter_assert.svh
// Assertion macros for the stick ADC reference filter.
// Used by the top level only; no other dependencies.
`ifndef STICK_ADC_REFERENCE_FILTER_ASSERT_SVH
`define STICK_ADC_REFERENCE_FILTER_ASSERT_SVH

`define SARF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SARF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sarf_pkg.sv
// Package for the stick ADC reference filter.
// Holds the widths shared by all modules and the filter constants.
package sarf_pkg;
  localparam int unsigned SampleW = 12;
  localparam int unsigned WideW = 13;
  localparam int unsigned ProdW = 25;
  localparam logic [12:0] IntRefNominal = 13'd1519;
  localparam logic [12:0] IntRefHigh = 13'd1719;
  localparam logic [12:0] IntRefLow = 13'd1319;
  localparam logic [12:0] ExtRefNominal = 13'd3102;
  localparam logic [12:0] ExtCheckLow = 13'd3002;
  localparam logic [12:0] ExtCheckHigh = 13'd3202;
  localparam logic [12:0] BatteryReset = 13'd3309;
  localparam logic [12:0] JumpLimit = 13'd30;
  localparam logic [12:0] SmoothLimit = 13'd20;

  function automatic logic [12:0] absdiff(logic [12:0] a, logic [12:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Exact floor((4*old+new)/5) for values below 2^15 via a reciprocal.
  function automatic logic [12:0] blend(logic [12:0] old, logic [12:0] cur);
    logic [14:0] s;
    logic [31:0] p;
    logic [14:0] q;
    logic [14:0] r;
    s = {old, 2'b00} + {2'b00, cur};
    p = 32'(s) * 32'd13107;
    q = p[30:16];
    r = s - 15'(q * 15'd5);
    if (r >= 15'd5) q = q + 15'd1;
    return q[12:0];
  endfunction

  function automatic logic [12:0] jump(logic [12:0] old, logic [12:0] cur);
    return (absdiff(old, cur) > JumpLimit) ? cur : blend(old, cur);
  endfunction
endpackage

### rtl/core/sarf_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sarf_pkg for widths.
module sarf_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sarf_pkg::ProdW-1:0]  dividend_i,
  input  logic [sarf_pkg::WideW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [sarf_pkg::ProdW-1:0]  quotient_o
);
  import sarf_pkg::*;

  logic [ProdW-1:0] quot_q, quot_d;
  logic [WideW:0]   rem_q, rem_d;
  logic [WideW-1:0] den_q, den_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WideW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[WideW-1:0], quot_q[ProdW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
      cnt_d = 5'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q} && den_q != '0) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // A zero divisor yields zero; the filter never divides by zero.
  assign quotient_o = (den_q == '0) ? '0 : quot_q;
  assign done_o = done_q;
endmodule

### rtl/core/stick_adc_reference_filter.sv
// Stick ADC reference filter: reference tracking, ratiometric correction
// and stick smoothing. Each item runs six divisions in turn on one shared
// bit-serial divider, then loads the output register once the last result
// has been taken and returns to idle; the result waits in an output
// register while the next item may be taken.
// Depends on sarf_pkg, sarf_divider and stick_adc_reference_filter_assert.svh.
`include "stick_adc_reference_filter_assert.svh"
module stick_adc_reference_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] int_ref_sample_i,
  input  logic [11:0] ext_ref_sample_i,
  input  logic [11:0] battery_sample_i,
  input  logic [11:0] rudder_sample_i,
  input  logic [11:0] stick_a_sample_i,
  input  logic [11:0] stick_b_sample_i,
  input  logic [11:0] aileron_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] rudder_out_o,
  output logic [11:0] throttle_out_o,
  output logic [11:0] elevator_out_o,
  output logic [11:0] aileron_out_o,
  output logic [12:0] battery_out_o,
  output logic        ext_ref_good_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import sarf_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StStart = 5'b00010,
    StWait  = 5'b00100,
    StApply = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic        mode_q;
  logic [11:0] max_q;
  logic [12:0] int_q, ext_q, bat_q;
  logic [11:0] stk_q [4];
  logic        trust_q;
  logic [2:0]  step_q;
  logic [11:0] smp_q [5];
  logic        ov_q;
  logic [11:0] o_stk_q [4];
  logic [12:0] o_bat_q;
  logic        o_tr_q;

  logic              dv_start, dv_done;
  logic [ProdW-1:0]  dv_num, dv_q;
  logic [WideW-1:0]  dv_den;
  logic [12:0]       x_cur, corr, sv, sv2;
  logic              accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // Step 0 is the reference check, steps 1..5 battery and the four sticks.
  always_comb begin
    x_cur = (step_q == 3'd0) ? ext_q : {1'b0, smp_q[3'(step_q - 3'd1)]};
    if (step_q == 3'd0 || !trust_q) begin
      dv_num = 25'(x_cur) * 25'(IntRefNominal);
      dv_den = int_q;
    end else begin
      dv_num = 25'(x_cur) * 25'(ExtRefNominal);
      dv_den = ext_q;
    end
  end
  assign dv_start = (state_q == StStart);

  sarf_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dv_num),
    .divisor_i(dv_den), .done_o(dv_done), .quotient_o(dv_q)
  );

  assign corr = dv_q[12:0];
  always_comb begin
    sv = corr;
    if (absdiff({1'b0, stk_q[2'(step_q - 3'd2)]}, corr) < SmoothLimit)
      sv = blend({1'b0, stk_q[2'(step_q - 3'd2)]}, corr);
    sv2 = (sv > {1'b0, max_q}) ? {1'b0, max_q} : sv;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StStart;
      StStart: state_d = StWait;
      StWait:  if (dv_done) state_d = StApply;
      StApply: state_d = (step_q == 3'd5) ? StOut : StStart;
      StOut:   if (!ov_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= 1'b0;
      max_q <= 12'hfff;
      int_q <= IntRefNominal;
      ext_q <= ExtRefNominal;
      bat_q <= BatteryReset;
      for (int i = 0; i < 4; i++) stk_q[i] <= '0;
      trust_q <= 1'b1;
      step_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i) max_q <= cfg_data_i;
        else mode_q <= cfg_data_i[0];
      end
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (accept) begin
        logic [12:0] ni;
        logic [12:0] ne;
        ni = jump(int_q, {1'b0, int_ref_sample_i});
        ne = jump(ext_q, {1'b0, ext_ref_sample_i});
        int_q <= (ni > IntRefHigh || ni < IntRefLow) ? IntRefNominal : ni;
        ext_q <= {1'b0, ne[11:0]};
        step_q <= '0;
      end
      if (state_q == StApply) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd0) begin
          if (dv_q < 25'(ExtCheckLow) || dv_q > 25'(ExtCheckHigh)) begin
            trust_q <= 1'b0;
            ext_q <= ExtRefNominal;
          end
        end else if (step_q == 3'd1) begin
          bat_q <= jump(bat_q, corr);
        end else begin
          stk_q[2'(step_q - 3'd2)] <= sv2[11:0];
        end
      end
      if (state_q == StOut && !ov_q) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[0] <= battery_sample_i;
      smp_q[1] <= rudder_sample_i;
      smp_q[2] <= mode_q ? stick_b_sample_i : stick_a_sample_i;
      smp_q[3] <= mode_q ? stick_a_sample_i : stick_b_sample_i;
      smp_q[4] <= aileron_sample_i;
    end
    if (state_q == StOut && !ov_q) begin
      for (int i = 0; i < 4; i++) o_stk_q[i] <= stk_q[i];
      o_bat_q <= bat_q;
      o_tr_q <= trust_q;
    end
  end

  assign out_valid_o = ov_q;
  assign rudder_out_o = o_stk_q[0];
  assign throttle_out_o = o_stk_q[1];
  assign elevator_out_o = o_stk_q[2];
  assign aileron_out_o = o_stk_q[3];
  assign battery_out_o = o_bat_q;
  assign ext_ref_good_o = o_tr_q;

  `SARF_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, state_q != StIdle, in_stall_o)
  `SARF_ASSERT_NEXT(a_trust_sticky, clk_i, rst_ni, !trust_q, !trust_q)
  `SARF_ASSERT_IMPL(a_int_window, clk_i, rst_ni, 1'b1,
      int_q >= IntRefLow && int_q <= IntRefHigh)
endmodule
